// File: design/stm_pkg.sv
// Package with shared types and constants for the sorted timer manager.
`timescale 1ns / 1ps
package stm_pkg;
    localparam int NumTimers = 16;
    localparam int SlotW = 4;
    localparam int LinkW = 5;
    localparam logic [LinkW-1:0] NilLink = 5'h1f;

    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_ALLOC = 3'd1;
    localparam logic [2:0] FUNC_FREE  = 3'd2;
    localparam logic [2:0] FUNC_INIT  = 3'd3;
    localparam logic [2:0] FUNC_ARM   = 3'd4;

    localparam logic [1:0] KIND_EXPIRE = 2'd0;
    localparam logic [1:0] KIND_ALLOC  = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_ARMED = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;      // capture the transaction and reply to simple ops
        logic       walk_init; // restart a list walk at the head
        logic       walk_step; // advance the walk by one entry
        logic       unlink;    // remove the entry at the walk cursor
        logic       insert;    // link the armed slot at the walk cursor
        logic       set_dl;    // compute and store the new deadline
        logic       pop;       // pop the head as an expiry result
        logic       tick_inc;  // advance the tick counter
        logic       finish;    // emit the acknowledge of a free or arm
        logic       quiet_end; // tick ends with no further expiry
    } stm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] func;
        logic       valid;
        logic       armed;
        logic       cur_nil;
        logic       cur_hit;   // cursor is the slot being unlinked
        logic       ins_here;  // new deadline <= deadline at cursor
        logic       head_due;  // head exists and is due
        logic       cnt_full;  // sixteen expiries already reported
    } stm_stat_t;
endpackage

// File: design/stm_ctrl.sv
// Controller state machine of the sorted timer manager.
`timescale 1ns / 1ps
module stm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  stm_pkg::stm_stat_t stat,
    output stm_pkg::stm_cmd_t  cmd
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DEC    = 7'b0000010,
        S_UNLINK = 7'b0000100,
        S_SETDL  = 7'b0001000,
        S_INSERT = 7'b0010000,
        S_TICK   = 7'b0100000,
        S_ACK    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.walk_init = 1'b1;
                state_next = S_IDLE;
                if (stat.func == stm_pkg::FUNC_TICK)
                begin
                    cmd.tick_inc = 1'b1;
                    state_next = S_TICK;
                end
                else if (stat.valid && (stat.func == stm_pkg::FUNC_FREE ||
                         stat.func == stm_pkg::FUNC_ARM))
                begin
                    if (stat.armed)
                        state_next = S_UNLINK;
                    else if (stat.func == stm_pkg::FUNC_ARM)
                        state_next = S_SETDL;
                    else
                        state_next = S_ACK;
                end
            end
            S_UNLINK:
            begin
                if (stat.cur_nil || stat.cur_hit)
                begin
                    cmd.unlink = stat.cur_hit;
                    cmd.walk_init = 1'b1;
                    state_next = (stat.func == stm_pkg::FUNC_ARM) ? S_SETDL : S_ACK;
                end
                else
                    cmd.walk_step = 1'b1;
            end
            S_SETDL:
            begin
                cmd.set_dl = 1'b1;
                cmd.walk_init = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                if (stat.cur_nil || stat.ins_here)
                begin
                    cmd.insert = 1'b1;
                    state_next = S_ACK;
                end
                else
                    cmd.walk_step = 1'b1;
            end
            S_TICK:
            begin
                if (stat.head_due && !stat.cnt_full)
                    cmd.pop = 1'b1;
                else
                begin
                    cmd.quiet_end = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ACK:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// File: design/stm_datapath.sv
// Datapath of the sorted timer manager: slot tables, list and result register.
`timescale 1ns / 1ps
module stm_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  stm_pkg::stm_cmd_t  cmd,
    output stm_pkg::stm_stat_t stat,
    input  logic [2:0]         func,
    input  logic [3:0]         slot,
    input  logic [31:0]        timeout,
    input  logic [7:0]         data_byte,
    input  logic [3:0]         dest,
    output logic               strobe,
    output logic [1:0]         kind,
    output logic [3:0]         out_slot,
    output logic               ok,
    output logic [7:0]         out_data,
    output logic [3:0]         out_dest,
    output logic               last
);
    localparam int N = stm_pkg::NumTimers;
    localparam int SW = stm_pkg::SlotW;
    localparam int LW = stm_pkg::LinkW;

    // Captured transaction.
    logic [2:0]  func_reg;
    logic [SW-1:0] slot_reg;
    logic [31:0] timeout_reg;

    // Slot tables and list state.
    logic [1:0]    status_reg [N];
    logic [31:0]   deadline_reg [N];
    logic [7:0]    payload_reg [N];
    logic [3:0]    dest_reg [N];
    logic [LW-1:0] link_reg [N];
    logic [LW-1:0] head_reg;
    logic [31:0]   tick_reg;

    // Walk cursor and previous entry.
    logic [LW-1:0] cur_reg, prev_reg;
    logic [4:0]    cnt_reg;

    // Result register.
    logic       strobe_reg;
    logic [1:0] kind_reg;
    logic [3:0] oslot_reg;
    logic       ok_reg;
    logic [7:0] odata_reg;
    logic [3:0] odest_reg;
    logic       last_reg;

    logic          cur_nil;
    logic [SW-1:0] cur_idx, head_idx;
    logic          free_found;
    logic [SW-1:0] free_idx;
    logic [LW-1:0] cur_link;

    assign cur_nil  = cur_reg[LW-1];
    assign cur_idx  = cur_reg[SW-1:0];
    assign head_idx = head_reg[SW-1:0];
    assign cur_link = link_reg[cur_idx];

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (status_reg[i] == stm_pkg::ST_FREE)
            begin
                free_found = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign stat.func     = func_reg;
    assign stat.valid    = 1'b1;
    assign stat.armed    = (status_reg[slot_reg] == stm_pkg::ST_ARMED);
    assign stat.cur_nil  = cur_nil;
    assign stat.cur_hit  = !cur_nil && (cur_idx == slot_reg);
    assign stat.ins_here = !cur_nil && (deadline_reg[slot_reg] <= deadline_reg[cur_idx]);
    assign stat.head_due = !head_reg[LW-1] && (deadline_reg[head_idx] <= tick_reg);
    assign stat.cnt_full = cnt_reg[4];

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            head_reg <= stm_pkg::NilLink;
            strobe_reg <= 1'b0;
            cnt_reg <= '0;
            cur_reg <= stm_pkg::NilLink;
            prev_reg <= stm_pkg::NilLink;
            for (int i = 0; i < N; i++)
                status_reg[i] <= stm_pkg::ST_FREE;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cmd.load)
            begin
                cnt_reg <= '0;
                case (func)
                    stm_pkg::FUNC_ALLOC:
                    begin
                        strobe_reg <= 1'b1;
                        if (free_found)
                            status_reg[free_idx] <= stm_pkg::ST_ALLOC;
                    end
                    stm_pkg::FUNC_INIT:
                        strobe_reg <= 1'b1;
                    default: ;
                endcase
            end
            if (cmd.walk_init)
            begin
                cur_reg <= head_reg;
                prev_reg <= stm_pkg::NilLink;
            end
            if (cmd.walk_step)
            begin
                prev_reg <= cur_reg;
                cur_reg <= cur_link;
            end
            if (cmd.unlink)
            begin
                if (prev_reg[LW-1])
                    head_reg <= cur_link;
                else
                    link_reg[prev_reg[SW-1:0]] <= cur_link;
            end
            if (cmd.insert)
            begin
                link_reg[slot_reg] <= cur_reg;
                if (prev_reg[LW-1])
                    head_reg <= {1'b0, slot_reg};
                else
                    link_reg[prev_reg[SW-1:0]] <= {1'b0, slot_reg};
            end
            if (cmd.set_dl)
                status_reg[slot_reg] <= stm_pkg::ST_ARMED;
            if (cmd.tick_inc)
                tick_reg <= tick_reg + 32'd1;
            if (cmd.pop)
            begin
                head_reg <= link_reg[head_idx];
                status_reg[head_idx] <= stm_pkg::ST_ALLOC;
                cnt_reg <= cnt_reg + 5'd1;
                strobe_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                strobe_reg <= 1'b1;
                if (func_reg == stm_pkg::FUNC_FREE)
                    status_reg[slot_reg] <= stm_pkg::ST_FREE;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            slot_reg <= slot;
            timeout_reg <= timeout;
            kind_reg <= (func == stm_pkg::FUNC_ALLOC) ? stm_pkg::KIND_ALLOC
                                                     : stm_pkg::KIND_ACK;
            oslot_reg <= (func == stm_pkg::FUNC_ALLOC) ? (free_found ? free_idx : 4'd0)
                                                      : slot;
            ok_reg <= (func == stm_pkg::FUNC_ALLOC) ? free_found : 1'b1;
            odata_reg <= '0;
            odest_reg <= '0;
            last_reg <= 1'b1;
            if (func == stm_pkg::FUNC_INIT)
            begin
                payload_reg[slot] <= data_byte;
                dest_reg[slot] <= dest;
            end
        end
        if (cmd.set_dl)
            deadline_reg[slot_reg] <= tick_reg + timeout_reg;
        if (cmd.pop)
        begin
            kind_reg <= stm_pkg::KIND_EXPIRE;
            oslot_reg <= head_idx;
            ok_reg <= 1'b0;
            odata_reg <= payload_reg[head_idx];
            odest_reg <= dest_reg[head_idx];
            last_reg <= 1'b0;
        end
        if (cmd.quiet_end)
            last_reg <= 1'b1;
        if (cmd.finish)
        begin
            kind_reg <= stm_pkg::KIND_ACK;
            oslot_reg <= slot_reg;
            ok_reg <= 1'b1;
            odata_reg <= '0;
            odest_reg <= '0;
            last_reg <= 1'b1;
        end
    end

    // An expiry passes through the ex_ delay registers so that the last mark is known when it leaves.
    logic hold_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else
            hold_reg <= cmd.pop ? 1'b1 : (cmd.quiet_end ? 1'b0 : hold_reg);
    end

    logic       ex_valid_reg;
    logic [3:0] ex_slot_reg;
    logic [7:0] ex_data_reg;
    logic [3:0] ex_dest_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ex_valid_reg <= 1'b0;
        else
            ex_valid_reg <= strobe_reg && (kind_reg == stm_pkg::KIND_EXPIRE) && hold_reg;
    end
    always_ff @(posedge clk)
    begin
        ex_slot_reg <= oslot_reg;
        ex_data_reg <= odata_reg;
        ex_dest_reg <= odest_reg;
    end

    // Expiries come from the delayed copy; other results leave directly.
    logic pop_out;
    assign pop_out = strobe_reg && (kind_reg == stm_pkg::KIND_EXPIRE);
    assign strobe   = ex_valid_reg || (strobe_reg && !pop_out);
    assign kind     = ex_valid_reg ? stm_pkg::KIND_EXPIRE : kind_reg;
    assign out_slot = ex_valid_reg ? ex_slot_reg : oslot_reg;
    assign ok       = ex_valid_reg ? 1'b0 : ok_reg;
    assign out_data = ex_valid_reg ? ex_data_reg : odata_reg;
    assign out_dest = ex_valid_reg ? ex_dest_reg : odest_reg;
    assign last     = ex_valid_reg ? !hold_reg : last_reg;
endmodule

// File: design/sorted_timer_manager_top.sv
// Top level of the sorted timer manager.
// Allocate and init results come from the result register after the transaction; free and arm
// results follow any list walks (one entry a cycle: unlink of an armed slot, then insert for arm).
// A tick gives its first expiry through the expiry delay registers, then one per cycle.
// busy stays high while the controller is away from idle and while the last expiry of a tick
// leaves; results cannot be stalled.
// Reset clears the counter, the list head and all slots to free.
`timescale 1ns / 1ps
module sorted_timer_manager_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [3:0]  slot,
    input  logic [31:0] timeout,
    input  logic [7:0]  data_byte,
    input  logic [3:0]  dest,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic [3:0]  out_slot,
    output logic        ok,
    output logic [7:0]  out_data,
    output logic [3:0]  out_dest,
    output logic        last
);
    stm_pkg::stm_cmd_t  cmd;
    stm_pkg::stm_stat_t stat;
    logic ctrl_busy, tail_reg;

    // The last expiry leaves in the cycle in which the controller returns to idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tail_reg <= 1'b0;
        else
            tail_reg <= cmd.quiet_end;
    end
    assign busy = ctrl_busy || tail_reg;

    stm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !tail_reg),
        .busy  (ctrl_busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    stm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .func      (func),
        .slot      (slot),
        .timeout   (timeout),
        .data_byte (data_byte),
        .dest      (dest),
        .strobe    (strobe),
        .kind      (kind),
        .out_slot  (out_slot),
        .ok        (ok),
        .out_data  (out_data),
        .out_dest  (out_dest),
        .last      (last)
    );
endmodule

// File: dv/sorted_timer_manager_top_tb.sv
// Self-checking testbench for the sorted timer manager: random commands against a timer-list predictor.
`timescale 1ns / 1ps
module sorted_timer_manager_top_tb;
    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  slot;
        logic [31:0] timeout;
        logic [7:0]  data_byte;
        logic [3:0]  dest;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] slot;
        logic       ok;
        logic [7:0] data;
        logic [3:0] dest;
        logic       last;
    } event_t;

    localparam logic [4:0] NO_SLOT = 5'h1f;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [31:0] timeout;
    logic [7:0]  data_byte;
    logic [3:0]  dest;
    logic        strobe;
    logic [1:0]  kind;
    logic [3:0]  out_slot;
    logic        ok;
    logic [7:0]  out_data;
    logic [3:0]  out_dest;
    logic        last;

    sorted_timer_manager_top u_dut (.*);

    // Predictor state mirroring the timer pool.
    logic [31:0] ticks;
    logic [1:0]  status [stm_pkg::NumTimers];
    logic [31:0] due_at [stm_pkg::NumTimers];
    logic [7:0]  pay    [stm_pkg::NumTimers];
    logic [3:0]  dst_id [stm_pkg::NumTimers];
    logic [4:0]  link   [stm_pkg::NumTimers];
    logic [4:0]  head;

    cmd_t   cmd_queue [$];
    event_t expected_events [$];
    int     error_count;
    int     sent_count;
    logic   took;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Remove a slot from the sorted list.
    function automatic void unlink_timer(input logic [3:0] s);
        logic [4:0] cur;
        logic [4:0] prev;
        cur = head;
        prev = NO_SLOT;
        while (cur != NO_SLOT)
        begin
            if (cur[3:0] == s)
            begin
                if (prev == NO_SLOT) head = link[cur[3:0]];
                else link[prev[3:0]] = link[cur[3:0]];
                return;
            end
            prev = cur;
            cur = link[cur[3:0]];
        end
    endfunction

    // Insert ahead of the first entry with an equal or later deadline.
    function automatic void insert_timer(input logic [3:0] s);
        logic [4:0] cur;
        logic [4:0] prev;
        cur = head;
        prev = NO_SLOT;
        while (cur != NO_SLOT && due_at[s] > due_at[cur[3:0]])
        begin
            prev = cur;
            cur = link[cur[3:0]];
        end
        link[s] = cur;
        if (prev == NO_SLOT) head = {1'b0, s};
        else link[prev[3:0]] = {1'b0, s};
    endfunction

    // Compute the results of one accepted transaction.
    function automatic void predict_timer_events(input cmd_t c);
        event_t ev;
        int n;
        int i;
        n = 0;
        ev = '0;
        case (c.func)
            stm_pkg::FUNC_TICK:
            begin
                ticks = ticks + 32'd1;
                while (n < 16 && head != NO_SLOT && due_at[head[3:0]] <= ticks)
                begin
                    ev = '0;
                    ev.kind = stm_pkg::KIND_EXPIRE;
                    ev.slot = head[3:0];
                    ev.data = pay[head[3:0]];
                    ev.dest = dst_id[head[3:0]];
                    status[head[3:0]] = stm_pkg::ST_ALLOC;
                    head = link[head[3:0]];
                    expected_events.push_back(ev);
                    n++;
                end
            end
            stm_pkg::FUNC_ALLOC:
            begin
                ev.kind = stm_pkg::KIND_ALLOC;
                for (i = 0; i < stm_pkg::NumTimers; i++)
                    if (status[i] == stm_pkg::ST_FREE) break;
                if (i < stm_pkg::NumTimers)
                begin
                    status[i] = stm_pkg::ST_ALLOC;
                    ev.slot = i[3:0];
                    ev.ok = 1'b1;
                end
                expected_events.push_back(ev);
                n = 1;
            end
            stm_pkg::FUNC_FREE, stm_pkg::FUNC_INIT, stm_pkg::FUNC_ARM:
            begin
                if (c.func == stm_pkg::FUNC_FREE)
                begin
                    if (status[c.slot] == stm_pkg::ST_ARMED) unlink_timer(c.slot);
                    status[c.slot] = stm_pkg::ST_FREE;
                end
                else if (c.func == stm_pkg::FUNC_INIT)
                begin
                    pay[c.slot] = c.data_byte;
                    dst_id[c.slot] = c.dest;
                end
                else
                begin
                    if (status[c.slot] == stm_pkg::ST_ARMED) unlink_timer(c.slot);
                    due_at[c.slot] = ticks + c.timeout;
                    status[c.slot] = stm_pkg::ST_ARMED;
                    insert_timer(c.slot);
                end
                ev.kind = stm_pkg::KIND_ACK;
                ev.slot = c.slot;
                ev.ok = 1'b1;
                expected_events.push_back(ev);
                n = 1;
            end
            default: ;
        endcase
        if (n > 0) expected_events[$].last = 1'b1;
    endfunction

    function automatic cmd_t make_cmd(input logic [2:0] f, input logic [3:0] s,
                                      input logic [31:0] t, input logic [7:0] d,
                                      input logic [3:0] q);
        make_cmd = {f, s, t, d, q};
    endfunction

    // Driver: hold a transaction until it is taken, then present the next one.
    always @(negedge clk)
    begin
        if (rst_n && start && !took)
            ;
        else if (rst_n)
        begin
            if (cmd_queue.size() > 0 &&
                ((sent_count >= 80 && sent_count < 130) || $urandom_range(99) >= 15))
            begin
                {func, slot, timeout, data_byte, dest} <= cmd_queue.pop_front();
                start <= 1'b1;
                sent_count++;
            end
            else
            begin
                start <= 1'b0;
                func <= 3'($urandom);
                slot <= 4'($urandom);
                timeout <= $urandom;
                data_byte <= 8'($urandom);
                dest <= 4'($urandom);
            end
        end
    end

    // Monitor: predict on acceptance, compare each strobed result.
    always @(posedge clk)
    begin
        took <= rst_n && start && !busy;
        if (rst_n && start && !busy)
            predict_timer_events(make_cmd(func, slot, timeout, data_byte, dest));
        if (rst_n && strobe)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d slot=%0d", $realtime, kind, out_slot);
                error_count++;
            end
            else
            begin
                event_t e;
                e = expected_events.pop_front();
                if (kind !== e.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $realtime, e.kind, kind);
                    error_count++;
                end
                if (out_slot !== e.slot)
                begin
                    $display("%0t: out_slot expected %0d actual %0d", $realtime, e.slot,
                             out_slot);
                    error_count++;
                end
                if (ok !== e.ok)
                begin
                    $display("%0t: ok expected %0d actual %0d", $realtime, e.ok, ok);
                    error_count++;
                end
                if (out_data !== e.data)
                begin
                    $display("%0t: out_data expected %0h actual %0h", $realtime, e.data,
                             out_data);
                    error_count++;
                end
                if (out_dest !== e.dest)
                begin
                    $display("%0t: out_dest expected %0d actual %0d", $realtime, e.dest,
                             out_dest);
                    error_count++;
                end
                if (last !== e.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $realtime, e.last, last);
                    error_count++;
                end
            end
        end
    end

    // Fill the command queue: directed checks, then random traffic.
    initial
    begin
        int k;
        logic [3:0] s;
        ticks = '0;
        head = NO_SLOT;
        for (k = 0; k < stm_pkg::NumTimers; k++)
        begin
            status[k] = stm_pkg::ST_FREE;
            due_at[k] = '0;
            pay[k] = '0;
            dst_id[k] = '0;
            link[k] = NO_SLOT;
        end
        error_count = 0;
        sent_count = 0;
        took = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        func = '0;
        slot = '0;
        timeout = '0;
        data_byte = '0;
        dest = '0;
        // Directed: fill the pool, overflow it, extremes, ties, wrap.
        for (k = 0; k < stm_pkg::NumTimers; k++)
        begin
            cmd_queue.push_back(make_cmd(stm_pkg::FUNC_INIT, k[3:0], '0,
                                         (k == 0) ? 8'h00 : 8'hff,
                                         (k == 0) ? 4'h0 : 4'hf));
        end
        cmd_queue.push_back(make_cmd(stm_pkg::FUNC_TICK, '0, '0, '0, '0));
        cmd_queue.push_back(make_cmd(3'd7, 4'hf, 32'hffffffff, 8'hff, 4'hf));
        cmd_queue.push_back(make_cmd(stm_pkg::FUNC_ARM, 4'd0, 32'd0, '0, '0));
        cmd_queue.push_back(make_cmd(stm_pkg::FUNC_ARM, 4'd1, 32'd2, '0, '0));
        cmd_queue.push_back(make_cmd(stm_pkg::FUNC_ARM, 4'd2, 32'd2, '0, '0));
        cmd_queue.push_back(make_cmd(stm_pkg::FUNC_ARM, 4'd3, 32'hffffffff, '0, '0));
        cmd_queue.push_back(make_cmd(stm_pkg::FUNC_ARM, 4'd1, 32'd1, '0, '0));
        cmd_queue.push_back(make_cmd(stm_pkg::FUNC_FREE, 4'd2, '0, '0, '0));
        cmd_queue.push_back(make_cmd(stm_pkg::FUNC_TICK, '0, '0, '0, '0));
        cmd_queue.push_back(make_cmd(stm_pkg::FUNC_TICK, '0, '0, '0, '0));
        for (k = 0; k < 17; k++)
            cmd_queue.push_back(make_cmd(stm_pkg::FUNC_ALLOC, '0, '0, '0, '0));
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Random traffic; a stretch in the middle is sent with no idling.
        for (k = 0; k < 120; k++)
        begin
            int r;
            s = 4'($urandom);
            r = $urandom_range(99);
            if (r < 20)
                cmd_queue.push_back(make_cmd(stm_pkg::FUNC_TICK, s, $urandom,
                                             8'($urandom), 4'($urandom)));
            else if (r < 30)
                cmd_queue.push_back(make_cmd(stm_pkg::FUNC_ALLOC, s, $urandom,
                                             8'($urandom), 4'($urandom)));
            else if (r < 42)
                cmd_queue.push_back(make_cmd(stm_pkg::FUNC_FREE, s, $urandom,
                                             8'($urandom), 4'($urandom)));
            else if (r < 55)
                cmd_queue.push_back(make_cmd(stm_pkg::FUNC_INIT, s, $urandom,
                                             8'($urandom), 4'($urandom)));
            else if (r < 95)
                cmd_queue.push_back(make_cmd(stm_pkg::FUNC_ARM, s,
                    ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(6)),
                    8'($urandom), 4'($urandom)));
            else
                cmd_queue.push_back(make_cmd(3'($urandom_range(7, 5)), s, $urandom,
                                             8'($urandom), 4'($urandom)));
        end
        // A run of ticks drains remaining short timers.
        for (k = 0; k < 20; k++)
            cmd_queue.push_back(make_cmd(stm_pkg::FUNC_TICK, '0, '0, '0, '0));
        while (cmd_queue.size() > 0 || start) @(posedge clk);
        while (expected_events.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0 && expected_events.size() == 0)
            $display("sorted_timer_manager_top_tb: clean");
        else
            $display("sorted_timer_manager_top_tb: errors");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5ms;
        $display("sorted_timer_manager_top_tb: errors");
        $finish;
    end
endmodule

// File: filelist.f
design/stm_pkg.sv
design/stm_ctrl.sv
design/stm_datapath.sv
design/sorted_timer_manager_top.sv
dv/sorted_timer_manager_top_tb.sv
